// ===== sv/stack_bytecode_alu_engine_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the stack bytecode ALU engine
// Clocked implication checks with asynchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef STACK_BYTECODE_ALU_ENGINE_MACROS_SVH
`define STACK_BYTECODE_ALU_ENGINE_MACROS_SVH

// Same-cycle implication
`define SBAE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication
`define SBAE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== sv/sbae_pkg.sv =====
// ----------------------------------------------------------------------------
// sbae_pkg
// Shared codes, types and defaults of the stack bytecode ALU engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package sbae_pkg;

	localparam int STACK_DEPTH_DEF = 32;
	localparam int MAX_NESTING_DEF = 255;

	// instruction codes
	localparam logic [4:0] F_PUSH  = 5'd0;
	localparam logic [4:0] F_POP   = 5'd1;
	localparam logic [4:0] F_ADD   = 5'd2;
	localparam logic [4:0] F_SUB   = 5'd3;
	localparam logic [4:0] F_MUL   = 5'd4;
	localparam logic [4:0] F_DIV   = 5'd5;
	localparam logic [4:0] F_REM   = 5'd6;
	localparam logic [4:0] F_POW   = 5'd7;
	localparam logic [4:0] F_AND   = 5'd8;
	localparam logic [4:0] F_OR    = 5'd9;
	localparam logic [4:0] F_SHL   = 5'd10;
	localparam logic [4:0] F_SHR   = 5'd11;
	localparam logic [4:0] F_LAND  = 5'd12;
	localparam logic [4:0] F_LOR   = 5'd13;
	localparam logic [4:0] F_LT    = 5'd14;
	localparam logic [4:0] F_LE    = 5'd15;
	localparam logic [4:0] F_GT    = 5'd16;
	localparam logic [4:0] F_GE    = 5'd17;
	localparam logic [4:0] F_EQ    = 5'd18;
	localparam logic [4:0] F_NEQ   = 5'd19;
	localparam logic [4:0] F_IF    = 5'd20;
	localparam logic [4:0] F_ENDIF = 5'd21;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_UNDER = 2'd1;
	localparam logic [1:0] ST_OVER  = 2'd2;
	localparam logic [1:0] ST_DIVZ  = 2'd3;

	typedef enum logic [2:0] {
		CL_PUSH, CL_POP, CL_BIN, CL_IF, CL_ENDIF, CL_NONE
	} cls_t;

	typedef struct packed {
		cls_t       cls;
		logic [4:0] func;
		logic [7:0] imm;
	} entry_t;

	typedef enum logic [1:0] {B_IDLE, B_EXEC, B_ITER} bstate_t;

	typedef enum logic [1:0] {U_IDLE, U_DIV, U_POW} umode_t;

	typedef enum logic [1:0] {IOP_DIV, IOP_REM, IOP_POW} iop_t;

	typedef struct packed {
		logic start;
		iop_t op;
	} iter_req_t;

endpackage

// ===== sv/sbae_iter.sv =====
// ----------------------------------------------------------------------------
// sbae_iter
// Iterative divide/remainder (one quotient bit a cycle) and integer power
// (one exponent bit a cycle, square and multiply).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sbae_iter (
	input  logic                clk,
	input  logic                arst_n,
	input  sbae_pkg::iter_req_t req,
	input  logic [15:0]         a,
	input  logic [15:0]         b,
	output logic                done,
	output logic [15:0]         res
);
	import sbae_pkg::*;

	umode_t      mode_q, mode_d;
	logic [16:0] acc_q;
	logic [15:0] quo_q, dv_q, base_q, r_q;
	logic [14:0] e_q;
	logic [4:0]  cnt_q;
	logic        qneg_q, rneg_q, rem_sel_q;
	logic [16:0] trial;
	logic        ge;
	logic [31:0] prod_r, prod_b;
	logic [15:0] a_mag, b_mag;

	assign a_mag  = a[15] ? 16'(-a) : a;
	assign b_mag  = b[15] ? 16'(-b) : b;
	assign trial  = {acc_q[15:0], quo_q[15]};
	assign ge     = trial >= {1'b0, dv_q};
	assign prod_r = r_q * base_q;
	assign prod_b = base_q * base_q;

	// next mode and completion
	always_comb begin
		mode_d = mode_q;
		done   = 1'b0;
		case (mode_q)
			U_IDLE: begin
				if (req.start) begin
					mode_d = (req.op == IOP_POW) ? U_POW : U_DIV;
				end
			end
			U_DIV: begin
				if (cnt_q == 5'd0) begin
					done   = 1'b1;
					mode_d = U_IDLE;
				end
			end
			U_POW: begin
				if (e_q == 15'd0) begin
					done   = 1'b1;
					mode_d = U_IDLE;
				end
			end
			default: mode_d = U_IDLE;
		endcase
	end

	// select result with sign fix
	always_comb begin
		if (mode_q == U_POW) begin
			res = r_q;
		end else if (rem_sel_q) begin
			res = rneg_q ? 16'(-acc_q[15:0]) : acc_q[15:0];
		end else begin
			res = qneg_q ? 16'(-quo_q) : quo_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= U_IDLE;
		end else begin
			mode_q <= mode_d;
		end
	end

	// load operands and advance one step a cycle
	always_ff @(posedge clk) begin
		case (mode_q)
			U_IDLE: begin
				if (req.start) begin
					acc_q     <= 17'd0;
					quo_q     <= a_mag;
					dv_q      <= b_mag;
					qneg_q    <= a[15] ^ b[15];
					rneg_q    <= a[15];
					rem_sel_q <= (req.op == IOP_REM);
					cnt_q     <= 5'd16;
					base_q    <= a;
					e_q       <= b[14:0];
					r_q       <= 16'd1;
				end
			end
			U_DIV: begin
				if (cnt_q != 5'd0) begin
					acc_q <= ge ? (trial - {1'b0, dv_q}) : trial;
					quo_q <= {quo_q[14:0], ge};
					cnt_q <= cnt_q - 5'd1;
				end
			end
			U_POW: begin
				if (e_q != 15'd0) begin
					if (e_q[0]) begin
						r_q <= prod_r[15:0];
					end
					base_q <= prod_b[15:0];
					e_q    <= {1'b0, e_q[14:1]};
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== sv/sbae_front.sv =====
// ----------------------------------------------------------------------------
// sbae_front
// Accept instructions, classify them and hold them in a two-entry queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sbae_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [4:0]       func,
	input  logic [7:0]       immediate,
	output logic             q_valid,
	output sbae_pkg::entry_t q_entry,
	input  logic             q_deq
);
	import sbae_pkg::*;

	entry_t     slot_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	cls_t       cls;
	logic       wr, rd;

	// classify the incoming instruction
	always_comb begin
		if (func == F_PUSH) begin
			cls = CL_PUSH;
		end else if (func == F_POP) begin
			cls = CL_POP;
		end else if (func >= F_ADD && func <= F_NEQ) begin
			cls = CL_BIN;
		end else if (func == F_IF) begin
			cls = CL_IF;
		end else if (func == F_ENDIF) begin
			cls = CL_ENDIF;
		end else begin
			cls = CL_NONE;
		end
	end

	assign full    = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_entry = slot_q[rp_q];
	assign wr      = push && !full;
	assign rd      = q_deq && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) begin
				wp_q <= !wp_q;
			end
			if (rd) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	// store the transfer
	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wp_q] <= '{cls: cls, func: func, imm: immediate};
		end
	end

endmodule

// ===== sv/sbae_back.sv =====
// ----------------------------------------------------------------------------
// sbae_back
// Execute queued instructions against the operand stack and register results.
// Top of stack lives in a register, the entries below it in a memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stack_bytecode_alu_engine_macros.svh"
module sbae_back #(
	parameter int STACK_DEPTH = sbae_pkg::STACK_DEPTH_DEF,
	parameter int MAX_NESTING = sbae_pkg::MAX_NESTING_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  sbae_pkg::entry_t   q_entry,
	output logic               q_deq,
	input  logic               pop,
	output logic               empty,
	output logic signed [15:0] top_value,
	output logic [5:0]         stack_depth,
	output logic [1:0]         status,
	output logic               skipping
);
	import sbae_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int NW = $clog2(MAX_NESTING + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
	localparam logic [NW-1:0] NEST_C  = NW'(MAX_NESTING);

	logic [15:0]   mem [STACK_DEPTH];
	bstate_t       state_q, state_d;
	entry_t        op_q;
	logic [CW-1:0] cnt_q, cnt_d, cnt_m1, cnt_m2;
	logic [15:0]   tos_q, tos_d, below_q, bin_res;
	logic [NW-1:0] nest_q, nest_d;
	logic [1:0]    st_d;
	logic          fin, wr_en, out_valid_q;
	iter_req_t     ireq;
	logic          idone;
	logic [15:0]   ires;
	logic [31:0]   prod;
	logic [CW+5:0] cnt_ext;
	logic signed [15:0] sa, sb;

	assign cnt_m1 = cnt_q - CW'(1);
	assign cnt_m2 = cnt_q - CW'(2);
	assign sa     = below_q;
	assign sb     = tos_q;
	assign prod   = below_q * tos_q;

	sbae_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ireq),
		.a      (below_q),
		.b      (tos_q),
		.done   (idone),
		.res    (ires)
	);

	// quick binary operations
	always_comb begin
		case (op_q.func)
			F_ADD:   bin_res = below_q + tos_q;
			F_SUB:   bin_res = below_q - tos_q;
			F_MUL:   bin_res = prod[15:0];
			F_AND:   bin_res = below_q & tos_q;
			F_OR:    bin_res = below_q | tos_q;
			F_SHL:   bin_res = (tos_q[15:4] != 12'd0) ? 16'd0 : (below_q << tos_q[3:0]);
			F_SHR:   bin_res = (tos_q[15:4] != 12'd0) ? {16{below_q[15]}}
				: 16'(sa >>> tos_q[3:0]);
			F_LAND:  bin_res = {15'd0, (below_q != 16'd0) && (tos_q != 16'd0)};
			F_LOR:   bin_res = {15'd0, (below_q != 16'd0) || (tos_q != 16'd0)};
			F_LT:    bin_res = {15'd0, sa < sb};
			F_LE:    bin_res = {15'd0, sa <= sb};
			F_GT:    bin_res = {15'd0, sa > sb};
			F_GE:    bin_res = {15'd0, sa >= sb};
			F_EQ:    bin_res = {15'd0, sa == sb};
			F_POW:   bin_res = 16'd0;
			default: bin_res = {15'd0, sa != sb};
		endcase
	end

	// next state, next stack contents and result
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		tos_d   = tos_q;
		nest_d  = nest_q;
		st_d    = ST_OK;
		fin     = 1'b0;
		wr_en   = 1'b0;
		q_deq   = 1'b0;
		ireq    = '{start: 1'b0, op: IOP_DIV};
		case (state_q)
			B_IDLE: begin
				if (q_valid && !out_valid_q) begin
					q_deq   = 1'b1;
					state_d = B_EXEC;
				end
			end
			B_EXEC: begin
				fin     = 1'b1;
				state_d = B_IDLE;
				if (nest_q != '0) begin
					if (op_q.cls == CL_IF) begin
						if (nest_q < NEST_C) begin
							nest_d = nest_q + NW'(1);
						end
					end else if (op_q.cls == CL_ENDIF) begin
						nest_d = nest_q - NW'(1);
					end
				end else begin
					case (op_q.cls)
						CL_PUSH: begin
							if (cnt_q >= DEPTH_C) begin
								st_d = ST_OVER;
							end else begin
								wr_en = (cnt_q != '0);
								tos_d = {8'd0, op_q.imm};
								cnt_d = cnt_q + CW'(1);
							end
						end
						CL_POP, CL_IF: begin
							if (cnt_q == '0) begin
								st_d = ST_UNDER;
							end else begin
								cnt_d = cnt_m1;
								tos_d = below_q;
								if (op_q.cls == CL_IF && tos_q == 16'd0) begin
									nest_d = NW'(1);
								end
							end
						end
						CL_BIN: begin
							if (cnt_q < CW'(2)) begin
								st_d = ST_UNDER;
							end else if ((op_q.func == F_DIV || op_q.func == F_REM)
								&& tos_q == 16'd0) begin
								st_d = ST_DIVZ;
							end else if (op_q.func == F_DIV || op_q.func == F_REM
								|| (op_q.func == F_POW && !tos_q[15])) begin
								fin        = 1'b0;
								state_d    = B_ITER;
								ireq.start = 1'b1;
								ireq.op    = (op_q.func == F_DIV) ? IOP_DIV
									: (op_q.func == F_REM) ? IOP_REM : IOP_POW;
							end else begin
								cnt_d = cnt_m1;
								tos_d = bin_res;
							end
						end
						default: ;
					endcase
				end
			end
			B_ITER: begin
				if (idone) begin
					fin     = 1'b1;
					cnt_d   = cnt_m1;
					tos_d   = ires;
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	assign cnt_ext = {6'd0, cnt_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			cnt_q       <= '0;
			nest_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			nest_q  <= nest_d;
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold top of stack, latch instruction, register result
	always_ff @(posedge clk) begin
		tos_q <= tos_d;
		if (q_deq) begin
			op_q <= q_entry;
		end
		if (fin) begin
			top_value   <= (cnt_d != '0) ? tos_d : 16'd0;
			stack_depth <= cnt_ext[5:0];
			status      <= st_d;
			skipping    <= (nest_d != '0);
		end
	end

	// stack memory below the top entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cnt_m1[AW-1:0]] <= tos_q;
		end
		below_q <= mem[cnt_m2[AW-1:0]];
	end

	assign empty = !out_valid_q;

	`SBAE_ASSERT_IMP(a_start_free, clk, arst_n, q_deq, !out_valid_q)
	`SBAE_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= DEPTH_C)
	`SBAE_ASSERT_IMP(a_iter_no_result, clk, arst_n, state_q == B_ITER, !out_valid_q)
	`SBAE_ASSERT_NXT(a_iter_enter, clk, arst_n, ireq.start, state_q == B_ITER)

endmodule

// ===== sv/stack_bytecode_alu_engine.sv =====
// Flow: a transfer is held in the front queue, dequeued in B_IDLE, executed in B_EXEC
// and registered; divide, remainder and power may also pass through B_ITER.
// Each instruction finishes before the next is dequeued, and none is dequeued until
// the last result is popped; the iterative divide/power unit steps one bit a cycle.
// Reset: asynchronous, active low; empties the stack, clears skip mode and queues.
// ----------------------------------------------------------------------------
// stack_bytecode_alu_engine
// Stack bytecode ALU: instruction queue front end and stack execution back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module stack_bytecode_alu_engine #(
	parameter int STACK_DEPTH = sbae_pkg::STACK_DEPTH_DEF,
	parameter int MAX_NESTING = sbae_pkg::MAX_NESTING_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [4:0]         func,
	input  logic [7:0]         immediate,
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] top_value,
	output logic [5:0]         stack_depth,
	output logic [1:0]         status,
	output logic               skipping
);
	import sbae_pkg::*;

	logic   q_valid, q_deq;
	entry_t q_entry;

	sbae_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.func      (func),
		.immediate (immediate),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_deq     (q_deq)
	);

	sbae_back #(
		.STACK_DEPTH (STACK_DEPTH),
		.MAX_NESTING (MAX_NESTING)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_entry     (q_entry),
		.q_deq       (q_deq),
		.pop         (pop),
		.empty       (empty),
		.top_value   (top_value),
		.stack_depth (stack_depth),
		.status      (status),
		.skipping    (skipping)
	);

endmodule
